// File: hw/rtl/ces_pkg.sv
package ces_pkg;

  // CIGAR operation codes as they arrive on op_code_i.
  typedef enum logic [3:0] {
    OP_M  = 4'd0,
    OP_I  = 4'd1,
    OP_D  = 4'd2,
    OP_N  = 4'd3,
    OP_S  = 4'd4,
    OP_H  = 4'd5,
    OP_P  = 4'd6,
    OP_EQ = 4'd7,
    OP_X  = 4'd8,
    OP_B  = 4'd9
  } op_e;

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_EXON_LEN   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_INTRON_LEN = 1'd1;

  localparam int LEN_W   = 28;
  localparam int REF_W   = 31;
  localparam int POS_W   = 31;
  localparam int COORD_W = 32;
  localparam int IDX_W   = 16;

  // Depth of the queue between the front and the back.
  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [COORD_W-1:0] start;
    logic [COORD_W-1:0] stop;
    logic [IDX_W-1:0]   index;
  } exon_t;

  // One queue entry per input item that yields an exon: an optional closed exon and an
  // optional final exon, both from the same read.
  typedef struct packed {
    logic [REF_W-1:0] ref_id;
    logic             strand_rev;
    logic             emit_a;
    logic             emit_b;
    exon_t            a;
    exon_t            b;
  } job_t;

endpackage

// File: hw/rtl/cigar_exon_splitter.sv
// Channel | Direction | Handshake               | Payload
// cfg     | in        | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
// in      | in        | in_valid_i/in_ready_o   | one CIGAR op with read fields
// out     | out       | out_valid_o/out_ready_i | one exon block
// One op is accepted per cycle while the two-entry queue has room; the front
// computes the exon update combinationally in that cycle.
// At best, an exon appears on the output in the cycle after its op is accepted.
// An op that yields two exons holds the output for two transactions.
// Reset clears the configuration, the read state and the queue; no memory sweep.
// A stalled output fills the queue, after which in_ready_o drops.
module cigar_exon_splitter (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [ces_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [ces_pkg::LEN_W-1:0]          cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic                               first_op_i,
  input  logic                               last_op_i,
  input  logic                               read_unmapped_i,
  input  logic [ces_pkg::REF_W-1:0]          ref_id_i,
  input  logic [ces_pkg::POS_W-1:0]          read_pos_i,
  input  logic                               strand_rev_i,
  input  logic [3:0]                         op_code_i,
  input  logic [ces_pkg::LEN_W-1:0]          op_len_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [ces_pkg::REF_W-1:0]          out_ref_id_o,
  output logic [ces_pkg::COORD_W-1:0]        exon_start_o,
  output logic [ces_pkg::COORD_W-1:0]        exon_end_o,
  output logic                               out_strand_rev_o,
  output logic [ces_pkg::IDX_W-1:0]          exon_index_o,
  output logic                               last_exon_o
);

  logic          push, full, pop, empty;
  ces_pkg::job_t push_data, head;

  ces_front u_front (
    .clk_i,
    .rst_ni,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_index_i,
    .cfg_data_i,
    .in_valid_i,
    .in_ready_o,
    .first_op_i,
    .last_op_i,
    .read_unmapped_i,
    .ref_id_i,
    .read_pos_i,
    .strand_rev_i,
    .op_code_i,
    .op_len_i,
    .push_o      (push),
    .push_data_o (push_data),
    .full_i      (full)
  );

  ces_queue u_queue (
    .clk_i,
    .rst_ni,
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .head_o      (head),
    .empty_o     (empty)
  );

  ces_back u_back (
    .clk_i,
    .rst_ni,
    .head_i      (head),
    .empty_i     (empty),
    .pop_o       (pop),
    .out_valid_o,
    .out_ready_i,
    .out_ref_id_o,
    .exon_start_o,
    .exon_end_o,
    .out_strand_rev_o,
    .exon_index_o,
    .last_exon_o
  );

endmodule

// File: hw/rtl/ces_front.sv
module ces_front (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [ces_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [ces_pkg::LEN_W-1:0]          cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic                               first_op_i,
  input  logic                               last_op_i,
  input  logic                               read_unmapped_i,
  input  logic [ces_pkg::REF_W-1:0]          ref_id_i,
  input  logic [ces_pkg::POS_W-1:0]          read_pos_i,
  input  logic                               strand_rev_i,
  input  logic [3:0]                         op_code_i,
  input  logic [ces_pkg::LEN_W-1:0]          op_len_i,
  output logic                               push_o,
  output ces_pkg::job_t                      push_data_o,
  input  logic                               full_i
);

  localparam int CW = ces_pkg::COORD_W;
  localparam int IW = ces_pkg::IDX_W;

  function automatic logic [IW-1:0] sat_inc(input logic [IW-1:0] v);
    return (v == '1) ? v : v + IW'(1);
  endfunction

  logic [ces_pkg::LEN_W-1:0] min_exon_q, min_intron_q;
  logic [CW-1:0]             cur_start_q, cur_start_d;
  logic [CW-1:0]             cur_end_q, cur_end_d;
  logic [IW-1:0]             done_q, done_d;
  logic [ces_pkg::REF_W-1:0] ref_q, ref_d;
  logic                      strand_q, strand_d;
  logic                      unm_q, unm_d;

  logic          in_acc;
  logic [CW-1:0] start0, end0, endn, new_start, new_end;
  logic [CW:0]   sum;
  logic [CW+1:0] lhs, rhs;
  logic [IW-1:0] done0, done1, done2;
  logic          is_ext, is_skip, closing, emit_a;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !full_i;
  assign in_acc      = in_valid_i && in_ready_o;

  always_comb begin
    is_ext  = 1'b0;
    is_skip = 1'b0;
    unique case (op_code_i) inside
      ces_pkg::OP_M, ces_pkg::OP_D, ces_pkg::OP_EQ, ces_pkg::OP_X: is_ext = 1'b1;
      ces_pkg::OP_N: is_skip = 1'b1;
      default: ;
    endcase
  end

  always_comb begin
    // A first op opens a new read: the exon starts empty just past read_pos.
    unm_d    = first_op_i ? read_unmapped_i : unm_q;
    ref_d    = first_op_i ? ref_id_i : ref_q;
    strand_d = first_op_i ? strand_rev_i : strand_q;
    end0     = first_op_i ? {1'b0, read_pos_i} : cur_end_q;
    start0   = first_op_i ? ({1'b0, read_pos_i} + CW'(1)) : cur_start_q;
    done0    = first_op_i ? '0 : done_q;

    sum  = {1'b0, end0} + (CW+1)'(op_len_i);
    endn = sum[CW] ? '1 : sum[CW-1:0];

    // Length end - start + 1 >= min_exon_len, kept free of negatives.
    lhs = (CW+2)'(end0) + (CW+2)'(1);
    rhs = (CW+2)'(start0) + (CW+2)'(min_exon_q);

    closing   = is_skip && (op_len_i >= min_intron_q);
    emit_a    = closing && ((done0 == '0) || (lhs >= rhs));
    new_end   = (is_ext || is_skip) ? endn : end0;
    new_start = closing ? ((endn == '1) ? endn : endn + CW'(1)) : start0;
    done1     = emit_a ? sat_inc(done0) : done0;
    done2     = last_op_i ? sat_inc(done1) : done1;

    cur_end_d   = unm_d ? end0 : new_end;
    cur_start_d = unm_d ? start0 : new_start;
    done_d      = unm_d ? done0 : done2;
  end

  always_comb begin
    push_data_o.ref_id     = ref_d;
    push_data_o.strand_rev = strand_d;
    push_data_o.emit_a     = emit_a;
    push_data_o.emit_b     = last_op_i;
    push_data_o.a.start    = start0;
    push_data_o.a.stop     = end0;
    push_data_o.a.index    = done0;
    push_data_o.b.start    = new_start;
    push_data_o.b.stop     = new_end;
    push_data_o.b.index    = done1;
  end

  assign push_o = in_acc && !unm_d && (emit_a || last_op_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_exon_q   <= '0;
      min_intron_q <= '0;
      cur_start_q  <= '0;
      cur_end_q    <= '0;
      done_q       <= '0;
      ref_q        <= '0;
      strand_q     <= 1'b0;
      unm_q        <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == ces_pkg::CFG_MIN_EXON_LEN) begin
          min_exon_q <= cfg_data_i;
        end
        if (cfg_index_i == ces_pkg::CFG_MIN_INTRON_LEN) begin
          min_intron_q <= cfg_data_i;
        end
      end
      if (in_acc) begin
        cur_start_q <= cur_start_d;
        cur_end_q   <= cur_end_d;
        done_q      <= done_d;
        ref_q       <= ref_d;
        strand_q    <= strand_d;
        unm_q       <= unm_d;
      end
    end
  end

`ifndef SYNTHESIS
  // The front never writes into a full queue.
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> !full_i) else $error("push into full queue");
`endif

endmodule

// File: hw/rtl/ces_queue.sv
module ces_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  ces_pkg::job_t push_data_i,
  output logic          full_o,
  input  logic          pop_i,
  output ces_pkg::job_t head_o,
  output logic          empty_o
);

  localparam int PW = ces_pkg::QPTR_W;
  localparam int CNW = ces_pkg::QCNT_W;

  ces_pkg::job_t     mem_q [ces_pkg::QDEPTH];
  logic [PW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [CNW-1:0]    count_q;

  function automatic logic [PW-1:0] ptr_next(input logic [PW-1:0] p);
    return (p == PW'(ces_pkg::QDEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  assign full_o  = (count_q == CNW'(ces_pkg::QDEPTH));
  assign empty_o = (count_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ptr_next(wr_ptr_q);
      end
      if (pop_i) begin
        rd_ptr_q <= ptr_next(rd_ptr_q);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + CNW'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - CNW'(1);
      end
    end
  end

`ifndef SYNTHESIS
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o) else $error("pop from empty queue");
  a_push_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |=> !empty_o) else $error("queue lost an entry");
`endif

endmodule

// File: hw/rtl/ces_back.sv
module ces_back (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  ces_pkg::job_t                      head_i,
  input  logic                               empty_i,
  output logic                               pop_o,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [ces_pkg::REF_W-1:0]          out_ref_id_o,
  output logic [ces_pkg::COORD_W-1:0]        exon_start_o,
  output logic [ces_pkg::COORD_W-1:0]        exon_end_o,
  output logic                               out_strand_rev_o,
  output logic [ces_pkg::IDX_W-1:0]          exon_index_o,
  output logic                               last_exon_o
);

  // Set once the closed exon of a two-exon entry has gone out.
  logic          half_q;
  logic          show_a, out_acc;
  ces_pkg::exon_t ex;

  assign show_a      = head_i.emit_a && !half_q;
  assign ex          = show_a ? head_i.a : head_i.b;
  assign out_valid_o = !empty_i;
  assign out_acc     = out_valid_o && out_ready_i;
  assign pop_o       = out_acc && (!show_a || !head_i.emit_b);

  assign out_ref_id_o     = head_i.ref_id;
  assign out_strand_rev_o = head_i.strand_rev;
  assign exon_start_o     = ex.start;
  assign exon_end_o       = ex.stop;
  assign exon_index_o     = ex.index;
  assign last_exon_o      = !show_a;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_q <= 1'b0;
    end else if (pop_o) begin
      half_q <= 1'b0;
    end else if (out_acc) begin
      half_q <= 1'b1;
    end
  end

`ifndef SYNTHESIS
  a_half_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    half_q |-> (!empty_i && head_i.emit_a && head_i.emit_b))
    else $error("second exon pending without a two-exon entry");
  a_pop_on_acc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> (out_valid_o && out_ready_i)) else $error("pop without transaction");
`endif

endmodule

// File: verif/cigar_exon_splitter_test.sv
package exon_tb_pkg;
  import ces_pkg::*;

  typedef struct packed {
    logic             is_first;
    logic             is_last;
    logic             unmapped;
    logic [REF_W-1:0] ref_id;
    logic [POS_W-1:0] pos;
    logic             strand;
    logic [3:0]       code;
    logic [LEN_W-1:0] len;
  } cigar_op_t;

  typedef struct packed {
    logic [REF_W-1:0]   ref_id;
    logic [COORD_W-1:0] start;
    logic [COORD_W-1:0] stop;
    logic               strand;
    logic [IDX_W-1:0]   index;
    logic               is_last;
  } exon_rec_t;

  // Tracks the read being split and holds the exons still owed by the block.
  class exon_scoreboard;
    logic [LEN_W-1:0]   min_exon_len;
    logic [LEN_W-1:0]   min_intron_len;
    logic [COORD_W-1:0] cur_start;
    logic [COORD_W-1:0] cur_end;
    logic [IDX_W-1:0]   exons_done;
    logic [REF_W-1:0]   held_ref_id;
    logic               held_strand;
    logic               held_unmapped;
    exon_rec_t          owed_exons[$];
    int unsigned        mismatches;
    int unsigned        exons_checked;

    function new();
      min_exon_len   = '0;
      min_intron_len = '0;
      cur_start      = '0;
      cur_end        = '0;
      exons_done     = '0;
      held_ref_id    = '0;
      held_strand    = 1'b0;
      held_unmapped  = 1'b0;
      mismatches     = 0;
      exons_checked  = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [LEN_W-1:0] value);
      if (idx == CFG_MIN_EXON_LEN) begin
        min_exon_len = value;
      end else begin
        min_intron_len = value;
      end
    endfunction

    local function logic [COORD_W-1:0] sat_add(logic [COORD_W-1:0] a, logic [COORD_W-1:0] b);
      logic [COORD_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[COORD_W] ? '1 : s[COORD_W-1:0];
    endfunction

    local function void owe_exon(logic is_last);
      owed_exons.push_back('{ref_id: held_ref_id, start: cur_start, stop: cur_end,
                             strand: held_strand, index: exons_done, is_last: is_last});
      if (exons_done != '1) begin
        exons_done++;
      end
    endfunction

    function void note_op(cigar_op_t op);
      logic [COORD_W-1:0] len32;
      longint             exon_len;
      len32 = COORD_W'(op.len);
      if (op.is_first) begin
        held_unmapped = op.unmapped;
        held_ref_id   = op.ref_id;
        held_strand   = op.strand;
        cur_end       = COORD_W'(op.pos);
        cur_start     = cur_end + 1;
        exons_done    = '0;
      end
      if (held_unmapped) begin
        return;
      end
      case (op.code) inside
        OP_M, OP_D, OP_EQ, OP_X: begin
          cur_end = sat_add(cur_end, len32);
        end
        OP_N: begin
          if (op.len >= min_intron_len) begin
            // Length is signed: a block that never grew has end below start.
            exon_len = longint'(cur_end) - longint'(cur_start) + 1;
            if (exons_done == '0 || exon_len >= longint'(min_exon_len)) begin
              owe_exon(1'b0);
            end
            cur_start = sat_add(sat_add(cur_end, len32), 1);
          end
          cur_end = sat_add(cur_end, len32);
        end
        default: ;
      endcase
      if (op.is_last) begin
        owe_exon(1'b1);
      end
    endfunction

    function void check_exon(exon_rec_t got);
      exon_rec_t want;
      exons_checked++;
      if (owed_exons.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%t unexpected exon: ref %h start %h end %h strand %b idx %0d last %b",
                   $realtime, got.ref_id, got.start, got.stop, got.strand, got.index,
                   got.is_last);
        end
        return;
      end
      want = owed_exons.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%t exon mismatch: expected ref %h start %h end %h strand %b idx %0d last %b",
                   $realtime, want.ref_id, want.start, want.stop, want.strand, want.index,
                   want.is_last);
          $display("%t                  got ref %h start %h end %h strand %b idx %0d last %b",
                   $realtime, got.ref_id, got.start, got.stop, got.strand, got.index,
                   got.is_last);
        end
      end
    endfunction

    function int unsigned owed();
      return owed_exons.size();
    endfunction
  endclass

endpackage

module cigar_exon_splitter_test;
  timeunit 1ns;
  timeprecision 1ps;

  import ces_pkg::*;
  import exon_tb_pkg::*;

  localparam logic [LEN_W-1:0] LEN_MAX = '1;
  localparam logic [REF_W-1:0] REF_MAX = '1;
  localparam logic [POS_W-1:0] POS_MAX = 31'd2147483646;
  localparam int unsigned FIRST_UNKNOWN_OP = 32'(OP_B) + 1;
  localparam logic [3:0] QUIET_OPS [5] = '{OP_I, OP_S, OP_H, OP_P, OP_B};
  localparam logic [3:0] EXTEND_OPS [8] = '{OP_D, OP_EQ, OP_X, OP_M, OP_D, OP_EQ, OP_X, OP_M};
  localparam logic [3:0] NO_OP_READ [7] = '{OP_S, OP_I, OP_H, OP_P, OP_B, 4'(FIRST_UNKNOWN_OP),
                                            4'hF};

  logic                 clk_i           = 1'b0;
  logic                 rst_ni          = 1'b0;
  logic                 cfg_valid_i     = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i     = '0;
  logic [LEN_W-1:0]     cfg_data_i      = '0;
  logic                 in_valid_i      = 1'b0;
  logic                 in_ready_o;
  logic                 first_op_i      = 1'b0;
  logic                 last_op_i       = 1'b0;
  logic                 read_unmapped_i = 1'b0;
  logic [REF_W-1:0]     ref_id_i        = '0;
  logic [POS_W-1:0]     read_pos_i      = '0;
  logic                 strand_rev_i    = 1'b0;
  logic [3:0]           op_code_i       = '0;
  logic [LEN_W-1:0]     op_len_i        = '0;
  logic                 out_valid_o;
  logic                 out_ready_i     = 1'b0;
  logic [REF_W-1:0]     out_ref_id_o;
  logic [COORD_W-1:0]   exon_start_o;
  logic [COORD_W-1:0]   exon_end_o;
  logic                 out_strand_rev_o;
  logic [IDX_W-1:0]     exon_index_o;
  logic                 last_exon_o;

  exon_scoreboard sb;
  int unsigned    send_max;
  int unsigned    recv_max;
  int unsigned    ops_sent;
  int unsigned    settings_used;

  cigar_exon_splitter dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic cigar_op_t mk_op(logic is_first, logic is_last, logic unmapped,
                                      logic [REF_W-1:0] ref_id, logic [POS_W-1:0] pos,
                                      logic strand, logic [3:0] code, logic [LEN_W-1:0] len);
    return '{is_first: is_first, is_last: is_last, unmapped: unmapped, ref_id: ref_id,
             pos: pos, strand: strand, code: code, len: len};
  endfunction

  function automatic logic [LEN_W-1:0] rand_len();
    case ($urandom_range(9, 0))
      0:       return '0;
      1:       return LEN_MAX;
      2, 3:    return LEN_W'($urandom);
      default: return LEN_W'($urandom_range(40, 0));
    endcase
  endfunction

  function automatic logic [POS_W-1:0] rand_pos();
    case ($urandom_range(3, 0))
      0:       return POS_MAX;
      1:       return POS_W'($urandom_range(1000, 0));
      default: return POS_W'($urandom_range(32'(POS_MAX), 0));
    endcase
  endfunction

  function automatic logic [3:0] rand_code();
    int unsigned p;
    p = $urandom_range(99, 0);
    if (p < 35) return OP_M;
    if (p < 55) return OP_N;
    if (p < 63) return OP_D;
    if (p < 68) return OP_EQ;
    if (p < 73) return OP_X;
    if (p < 93) return QUIET_OPS[$urandom_range(4, 0)];
    return 4'($urandom_range(15, FIRST_UNKNOWN_OP));
  endfunction

  // Holds valid across back-to-back ops; it only drops when a gap is drawn.
  task automatic send_op(cigar_op_t op);
    int unsigned gap;
    gap = (send_max != 0) ? $urandom_range(send_max, 0) : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    first_op_i      <= op.is_first;
    last_op_i       <= op.is_last;
    read_unmapped_i <= op.unmapped;
    ref_id_i        <= op.ref_id;
    read_pos_i      <= op.pos;
    strand_rev_i    <= op.strand;
    op_code_i       <= op.code;
    op_len_i        <= op.len;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.note_op(op);
    ops_sent++;
  endtask

  task automatic set_thresholds(logic [LEN_W-1:0] exon_floor, logic [LEN_W-1:0] intron_min);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= CFG_MIN_EXON_LEN;
    cfg_data_i  <= exon_floor;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.set_reg(CFG_MIN_EXON_LEN, exon_floor);
    cfg_index_i <= CFG_MIN_INTRON_LEN;
    cfg_data_i  <= intron_min;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.set_reg(CFG_MIN_INTRON_LEN, intron_min);
    cfg_valid_i <= 1'b0;
    settings_used++;
  endtask

  // Ops that produce no exon may still be in flight once the queue is empty.
  task automatic drain();
    while (sb.owed() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic run_reads(int unsigned n_items);
    int unsigned      sent;
    int unsigned      nops;
    int unsigned      pick;
    logic             long_read;
    logic             broken;
    logic             no_first;
    logic             no_last;
    logic             unmapped;
    logic             strand;
    logic [REF_W-1:0] rid;
    logic [POS_W-1:0] pos;
    logic [3:0]       code;
    logic [LEN_W-1:0] len;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(99, 0);
      if (pick < 10) begin
        send_op(mk_op(1'($urandom), 1'($urandom), ($urandom_range(9, 0) == 0),
                      REF_W'($urandom), rand_pos(), 1'($urandom),
                      4'($urandom_range(15, 0)), rand_len()));
        sent++;
      end else begin
        // Long reads of full-length ops push the coordinates into saturation.
        long_read = (pick < 14);
        broken    = (pick >= 14 && pick < 22);
        nops      = long_read ? 12 : $urandom_range(8, 1);
        no_first  = broken && ($urandom_range(1, 0) == 1);
        no_last   = broken && !no_first;
        unmapped  = ($urandom_range(11, 0) == 0);
        rid       = REF_W'($urandom);
        pos       = rand_pos();
        strand    = 1'($urandom);
        for (int k = 0; k < int'(nops); k++) begin
          code = long_read ? ((k % 3 == 2) ? OP_N : OP_M) : rand_code();
          len  = long_read ? LEN_MAX : rand_len();
          send_op(mk_op(k == 0 && !no_first, k == int'(nops) - 1 && !no_last, unmapped,
                        rid, pos, strand, code, len));
        end
        sent += nops;
      end
    end
  endtask

  initial begin
    exon_rec_t   got;
    int unsigned stall;
    @(posedge rst_ni);
    forever begin
      stall = (recv_max != 0) ? $urandom_range(recv_max, 0) : 0;
      if (stall != 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
      got = '{ref_id: out_ref_id_o, start: exon_start_o, stop: exon_end_o,
              strand: out_strand_rev_o, index: exon_index_o, is_last: last_exon_o};
      sb.check_exon(got);
    end
  end

  initial begin
    #5_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  initial begin
    logic [LEN_W-1:0] exon_floor;
    logic [LEN_W-1:0] intron_min;
    sb            = new();
    send_max      = 16;
    recv_max      = 16;
    ops_sent      = 0;
    settings_used = 0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    set_thresholds('0, '0);
    // Nothing latched yet, so this op continues the cleared read state.
    send_op(mk_op(1'b0, 1'b1, 1'b0, '0, '0, 1'b0, OP_M, 28'd5));
    send_op(mk_op(1'b1, 1'b0, 1'b0, REF_MAX, POS_MAX, 1'b1, OP_M, LEN_MAX));
    foreach (EXTEND_OPS[k]) begin
      send_op(mk_op(1'b0, 1'b0, 1'b0, REF_MAX, POS_MAX, 1'b1, EXTEND_OPS[k], LEN_MAX));
    end
    // A skip on the last op closes one exon and emits the final one.
    send_op(mk_op(1'b0, 1'b1, 1'b0, REF_MAX, POS_MAX, 1'b1, OP_N, LEN_MAX));
    send_op(mk_op(1'b1, 1'b0, 1'b1, 31'd12345, 31'd1000, 1'b1, OP_M, 28'd20));
    send_op(mk_op(1'b0, 1'b0, 1'b1, 31'd12345, 31'd1000, 1'b1, OP_N, 28'd10));
    send_op(mk_op(1'b0, 1'b1, 1'b0, 31'd12345, 31'd1000, 1'b1, OP_M, 28'd7));
    foreach (NO_OP_READ[k]) begin
      send_op(mk_op(k == 0, k == 6, 1'b0, '0, '0, 1'b0, NO_OP_READ[k], 28'd3));
    end
    // Continues the previous read after its last mark.
    send_op(mk_op(1'b0, 1'b1, 1'b0, '0, '0, 1'b0, OP_EQ, 28'd2));
    in_valid_i <= 1'b0;
    drain();

    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        0: begin exon_floor = '0;      intron_min = '0;      send_max = 16; recv_max = 16; end
        1: begin exon_floor = LEN_MAX; intron_min = LEN_MAX; send_max = 0;  recv_max = 0;  end
        2: begin
          exon_floor = LEN_W'($urandom_range(40, 1));
          intron_min = LEN_W'($urandom_range(40, 1));
          send_max   = 0;
          recv_max   = 16;
        end
        3: begin exon_floor = LEN_MAX; intron_min = '0;      send_max = 16; recv_max = 0;  end
        4: begin exon_floor = '0;      intron_min = LEN_MAX; send_max = 16; recv_max = 16; end
        5: begin
          exon_floor = LEN_W'($urandom);
          intron_min = LEN_W'($urandom_range(40, 0));
          send_max   = 0;
          recv_max   = 0;
        end
        default: begin
          exon_floor = LEN_W'($urandom_range(40, 0));
          intron_min = LEN_W'($urandom_range(40, 0));
          send_max   = 16;
          recv_max   = 16;
        end
      endcase
      set_thresholds(exon_floor, intron_min);
      run_reads(112);
      in_valid_i <= 1'b0;
      drain();
    end

    $display("Sent %0d CIGAR ops under %0d threshold settings; checked %0d exon blocks.",
             ops_sent, settings_used, sb.exons_checked);
    if (sb.mismatches == 0 && sb.owed() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
